/* hw/rtl/srax_pkg.sv */
package srax_pkg;

    // default geometry
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF  = 31;
    localparam int COUNT_BITS      = 16;

    // register reset values
    localparam int MODULUS_RESET = 32003;
    localparam int SCALE_RESET   = 1;

    // register indexes
    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_SCALE   = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_ENTRY    = 2'd0;
    localparam logic [1:0] KIND_ROW_END  = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    // decoded input operations
    typedef enum logic [1:0] {
        OP_PUSH_P = 2'd0,
        OP_PUSH_Q = 2'd1,
        OP_END_P  = 2'd2,
        OP_END_Q  = 2'd3
    } op_t;

endpackage

/* hw/rtl/srax_front.sv */
module srax_front #(
    parameter int COLUMN_BITS = 16,
    parameter int VALUE_BITS  = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             cmd,
    input  logic [COLUMN_BITS-1:0] entry_column,
    input  logic [VALUE_BITS-1:0]  entry_value,
    output logic                   item_valid,
    input  logic                   item_ready,
    output srax_pkg::op_t          item_op,
    output logic [COLUMN_BITS-1:0] item_column,
    output logic [VALUE_BITS-1:0]  item_value
);
    import srax_pkg::*;

    op_t                   op_mem [2];
    logic [COLUMN_BITS-1:0] col_mem [2];
    logic [VALUE_BITS-1:0]  val_mem [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    op_t                    dec_op;
    logic                   push;
    logic                   pop;

    // classify the incoming command
    always_comb
    begin
        unique case (cmd)
            2'd0:    dec_op = OP_PUSH_P;
            2'd1:    dec_op = OP_PUSH_Q;
            2'd2:    dec_op = OP_END_P;
            default: dec_op = OP_END_Q;
        endcase
    end

    assign in_ready   = (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign item_valid = (cnt_reg != 2'd0);
    assign pop        = item_valid && item_ready;

    assign item_op     = op_mem[rd_ptr_reg];
    assign item_column = col_mem[rd_ptr_reg];
    assign item_value  = val_mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // two-beat queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]  <= dec_op;
            col_mem[wr_ptr_reg] <= entry_column;
            val_mem[wr_ptr_reg] <= entry_value;
        end
    end

endmodule

/* hw/rtl/srax_modred.sv */
module srax_modred #(
    parameter int VALUE_BITS = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2*VALUE_BITS+1:0]   dividend,
    input  logic [VALUE_BITS-1:0]     modulus,
    output logic                      done,
    output logic [VALUE_BITS-1:0]     remainder
);
    import srax_pkg::*;

    localparam int DW    = 2 * VALUE_BITS + 2;
    localparam int STEPS = DW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DW-1:0]         sh_reg;
    logic [VALUE_BITS:0]   rem_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  done_reg;
    logic [VALUE_BITS+1:0] mext;
    logic [VALUE_BITS+1:0] t1;
    logic [VALUE_BITS+1:0] t2;
    logic [VALUE_BITS:0]   rem_next;

    assign mext = {2'b00, modulus};

    // two restoring steps per cycle
    always_comb
    begin
        t1 = {rem_reg, sh_reg[DW-1]};
        if (t1 >= mext)
        begin
            t1 = t1 - mext;
        end
        t2 = {t1[VALUE_BITS:0], sh_reg[DW-2]};
        if (t2 >= mext)
        begin
            t2 = t2 - mext;
        end
        rem_next = t2[VALUE_BITS:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // modulus zero reduces mod 2^VALUE_BITS: no iterations
                if (modulus == '0)
                begin
                    cnt_reg  <= '0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= CW'(STEPS);
                end
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= (modulus == '0) ? {1'b0, dividend[VALUE_BITS-1:0]} : '0;
        end
        else if (cnt_reg != '0)
        begin
            sh_reg  <= {sh_reg[DW-3:0], 2'b00};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[VALUE_BITS-1:0];

endmodule

/* hw/rtl/srax_back.sv */
module srax_back #(
    parameter int QUEUE_DEPTH = 32,
    parameter int COLUMN_BITS = 16,
    parameter int VALUE_BITS  = 31
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  srax_pkg::op_t               item_op,
    input  logic [COLUMN_BITS-1:0]      item_column,
    input  logic [VALUE_BITS-1:0]       item_value,
    input  logic                        cfg_we,
    input  logic                        cfg_sel,
    input  logic [VALUE_BITS-1:0]       cfg_wdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [COLUMN_BITS-1:0]      out_column,
    output logic [VALUE_BITS-1:0]       out_value,
    output logic [srax_pkg::COUNT_BITS-1:0] term_count,
    output logic                        last
);
    import srax_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = COLUMN_BITS + VALUE_BITS;
    localparam int DW = 2 * VALUE_BITS + 2;
    localparam int PW = 2 * VALUE_BITS;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WAIT  = 9'b000000010,
        S_EVAL  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_ADD   = 9'b000010000,
        S_RED   = 9'b000100000,
        S_RES   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_FLUSH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [VALUE_BITS-1:0] modulus_reg;
    logic [VALUE_BITS-1:0] scale_reg;

    // entry queues
    logic [EW-1:0] p_mem [QUEUE_DEPTH];
    logic [EW-1:0] q_mem [QUEUE_DEPTH];
    logic [EW-1:0] p_rdata_reg;
    logic [EW-1:0] q_rdata_reg;
    logic [AW-1:0] p_head_reg, p_tail_reg, q_head_reg, q_tail_reg;
    logic [FW-1:0] p_fill_reg, q_fill_reg;
    logic          p_ended_reg, q_ended_reg;
    logic          p_push, q_push, p_pop, q_pop;
    logic          p_full, q_full;

    logic [COUNT_BITS-1:0] count_reg;
    logic                  eq_reg;
    logic [PW-1:0]         prod_reg;

    // result hold and output stage
    logic                   hold_v_reg;
    logic [1:0]             hold_kind_reg;
    logic [COLUMN_BITS-1:0] hold_col_reg;
    logic [VALUE_BITS-1:0]  hold_val_reg;
    logic [COUNT_BITS-1:0]  hold_cnt_reg;
    logic                   out_v_reg;
    logic [1:0]             out_kind_reg;
    logic [COLUMN_BITS-1:0] out_col_reg;
    logic [VALUE_BITS-1:0]  out_val_reg;
    logic [COUNT_BITS-1:0]  out_cnt_reg;
    logic                   out_last_reg;

    logic                   out_free;
    logic                   can_emit;
    logic                   emit_req;
    logic                   emit_go;
    logic                   flush_go;
    logic [1:0]             emit_kind;
    logic [COLUMN_BITS-1:0] emit_col;
    logic [VALUE_BITS-1:0]  emit_val;
    logic                   row_clear;
    logic                   set_p_end, set_q_end;
    logic                   eq_load;

    logic [COLUMN_BITS-1:0] p_head_col, q_head_col;
    logic [VALUE_BITS-1:0]  p_head_val, q_head_val;
    logic                   p_have, q_have;
    logic                   row_done;

    logic                   mod_start;
    logic [DW-1:0]          mod_dividend;
    logic                   mod_done;
    logic [VALUE_BITS-1:0]  mod_rem;

    assign p_head_col = p_rdata_reg[EW-1:VALUE_BITS];
    assign p_head_val = p_rdata_reg[VALUE_BITS-1:0];
    assign q_head_col = q_rdata_reg[EW-1:VALUE_BITS];
    assign q_head_val = q_rdata_reg[VALUE_BITS-1:0];
    assign p_have     = (p_fill_reg != '0);
    assign q_have     = (q_fill_reg != '0);
    assign p_full     = (p_fill_reg == FW'(QUEUE_DEPTH));
    assign q_full     = (q_fill_reg == FW'(QUEUE_DEPTH));
    assign row_done   = p_ended_reg && q_ended_reg && !p_have && !q_have;

    assign out_free   = !out_v_reg || out_ready;
    assign can_emit   = !hold_v_reg || out_free;
    assign emit_go    = emit_req && can_emit;
    assign item_ready = (state_reg == S_IDLE);

    assign mod_start    = (state_reg == S_ADD);
    assign mod_dividend = DW'(prod_reg) + DW'(eq_reg ? p_head_val : '0);

    srax_modred #(
        .VALUE_BITS (VALUE_BITS)
    ) u_modred (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .modulus   (modulus_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        emit_req   = 1'b0;
        emit_kind  = KIND_ENTRY;
        emit_col   = '0;
        emit_val   = '0;
        flush_go   = 1'b0;
        p_push     = 1'b0;
        q_push     = 1'b0;
        p_pop      = 1'b0;
        q_pop      = 1'b0;
        row_clear  = 1'b0;
        set_p_end  = 1'b0;
        set_q_end  = 1'b0;
        eq_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_WAIT;
                    unique case (item_op)
                        OP_PUSH_P:
                        begin
                            if (!p_ended_reg)
                            begin
                                if (p_full)
                                begin
                                    emit_req  = 1'b1;
                                    emit_kind = KIND_OVERFLOW;
                                    emit_col  = item_column;
                                    emit_val  = item_value;
                                end
                                else
                                begin
                                    p_push = 1'b1;
                                end
                            end
                        end
                        OP_PUSH_Q:
                        begin
                            if (!q_ended_reg)
                            begin
                                if (q_full)
                                begin
                                    emit_req  = 1'b1;
                                    emit_kind = KIND_OVERFLOW;
                                    emit_col  = item_column;
                                    emit_val  = item_value;
                                end
                                else
                                begin
                                    q_push = 1'b1;
                                end
                            end
                        end
                        OP_END_P: set_p_end = 1'b1;
                        default:  set_q_end = 1'b1;
                    endcase
                end
            end
            S_WAIT:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                priority if (p_have && q_have)
                begin
                    if (p_head_col > q_head_col)
                    begin
                        emit_req = 1'b1;
                        emit_col = p_head_col;
                        emit_val = p_head_val;
                        if (can_emit)
                        begin
                            p_pop      = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    else
                    begin
                        eq_load    = 1'b1;
                        state_next = S_MUL;
                    end
                end
                else if (p_have && q_ended_reg)
                begin
                    emit_req = 1'b1;
                    emit_col = p_head_col;
                    emit_val = p_head_val;
                    if (can_emit)
                    begin
                        p_pop      = 1'b1;
                        state_next = S_WAIT;
                    end
                end
                else if (q_have && p_ended_reg)
                begin
                    eq_load    = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_RED;
            end
            S_RED:
            begin
                if (mod_done)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                // equal columns that cancel give nothing
                if (eq_reg && (mod_rem == '0))
                begin
                    p_pop      = 1'b1;
                    q_pop      = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    emit_req = 1'b1;
                    emit_col = q_head_col;
                    emit_val = mod_rem;
                    if (can_emit)
                    begin
                        p_pop      = eq_reg;
                        q_pop      = 1'b1;
                        state_next = S_WAIT;
                    end
                end
            end
            S_FIN:
            begin
                if (row_done)
                begin
                    emit_req  = 1'b1;
                    emit_kind = KIND_ROW_END;
                    if (can_emit)
                    begin
                        row_clear  = 1'b1;
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!hold_v_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    flush_go   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            modulus_reg <= VALUE_BITS'(MODULUS_RESET);
            scale_reg   <= VALUE_BITS'(SCALE_RESET);
            p_head_reg  <= '0;
            p_tail_reg  <= '0;
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
            p_fill_reg  <= '0;
            q_fill_reg  <= '0;
            p_ended_reg <= 1'b0;
            q_ended_reg <= 1'b0;
            count_reg   <= '0;
            hold_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_sel == REG_MODULUS)
                begin
                    modulus_reg <= cfg_wdata;
                end
                else
                begin
                    scale_reg <= cfg_wdata;
                end
            end
            if (p_push)
            begin
                p_tail_reg <= (p_tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : p_tail_reg + 1'b1;
                p_fill_reg <= p_fill_reg + 1'b1;
            end
            if (q_push)
            begin
                q_tail_reg <= (q_tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : q_tail_reg + 1'b1;
                q_fill_reg <= q_fill_reg + 1'b1;
            end
            if (p_pop)
            begin
                p_head_reg <= (p_head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : p_head_reg + 1'b1;
                p_fill_reg <= p_fill_reg - 1'b1;
            end
            if (q_pop)
            begin
                q_head_reg <= (q_head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : q_head_reg + 1'b1;
                q_fill_reg <= q_fill_reg - 1'b1;
            end
            if (set_p_end)
            begin
                p_ended_reg <= 1'b1;
            end
            if (set_q_end)
            begin
                q_ended_reg <= 1'b1;
            end
            if (row_clear)
            begin
                p_ended_reg <= 1'b0;
                q_ended_reg <= 1'b0;
                count_reg   <= '0;
            end
            else if (emit_go && (emit_kind == KIND_ENTRY) && (count_reg != '1))
            begin
                count_reg <= count_reg + 1'b1;
            end
            // output stage: drain, then refill from hold
            if (out_v_reg && out_ready)
            begin
                out_v_reg <= 1'b0;
            end
            if (emit_go)
            begin
                hold_v_reg <= 1'b1;
                if (hold_v_reg)
                begin
                    out_v_reg <= 1'b1;
                end
            end
            if (flush_go)
            begin
                hold_v_reg <= 1'b0;
                out_v_reg  <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (eq_load)
        begin
            eq_reg <= p_have && q_have && (p_head_col == q_head_col);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PW'(scale_reg) * PW'(q_head_val);
        end
        if (emit_go)
        begin
            hold_kind_reg <= emit_kind;
            hold_col_reg  <= emit_col;
            hold_val_reg  <= emit_val;
            hold_cnt_reg  <= (emit_kind == KIND_ROW_END) ? count_reg : '0;
        end
        if ((emit_go && hold_v_reg) || flush_go)
        begin
            out_kind_reg <= hold_kind_reg;
            out_col_reg  <= hold_col_reg;
            out_val_reg  <= hold_val_reg;
            out_cnt_reg  <= hold_cnt_reg;
            out_last_reg <= flush_go;
        end
    end

    // queue memories
    always_ff @(posedge clk)
    begin
        if (p_push)
        begin
            p_mem[p_tail_reg] <= {item_column, item_value};
        end
        p_rdata_reg <= p_mem[p_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem[q_tail_reg] <= {item_column, item_value};
        end
        q_rdata_reg <= q_mem[q_head_reg];
    end

    assign out_valid  = out_v_reg;
    assign kind       = out_kind_reg;
    assign out_column = out_col_reg;
    assign out_value  = out_val_reg;
    assign term_count = out_cnt_reg;
    assign last       = out_last_reg;

    // fills stay within the queue depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (p_fill_reg <= FW'(QUEUE_DEPTH)) && (q_fill_reg <= FW'(QUEUE_DEPTH)))
        else $error("queue fill beyond depth");

    // between items at most one side holds entries
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(p_have && q_have))
        else $error("both queues hold entries while idle");

    // every result is flushed before the next item
    a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_v_reg)
        else $error("result left in hold while idle");

    // a finished reduction is only seen while waiting for it
    a_red_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_RED))
        else $error("reduction finished outside its wait state");

endmodule

/* hw/rtl/sparse_row_axpy_mod_p.sv */
// path: an input beat is registered in the front queue before the back takes it; a merged
// P-only entry is emitted from S_EVAL, a product entry through S_MUL, S_ADD, S_RED and S_RES
// (radix-4 remainder unit, 2 bits per cycle); the back works one item at a time, taking
// items only in S_IDLE, while a 2-beat queue keeps the input side accepting
// reset: asynchronous active-low; queues empty, row flags and count cleared,
// modulus 32003, scale 1; queue memories are not cleared
module sparse_row_axpy_mod_p #(
    parameter int QUEUE_DEPTH = srax_pkg::QUEUE_DEPTH_DEF,
    parameter int COLUMN_BITS = srax_pkg::COLUMN_BITS_DEF,
    parameter int VALUE_BITS  = srax_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      cmd,
    input  logic [COLUMN_BITS-1:0]          entry_column,
    input  logic [VALUE_BITS-1:0]           entry_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      kind,
    output logic [COLUMN_BITS-1:0]          out_column,
    output logic [VALUE_BITS-1:0]           out_value,
    output logic [srax_pkg::COUNT_BITS-1:0] term_count,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [VALUE_BITS-1:0]           cfg_data
);
    import srax_pkg::*;

    logic                   item_valid;
    logic                   item_ready;
    op_t                    item_op;
    logic [COLUMN_BITS-1:0] item_column;
    logic [VALUE_BITS-1:0]  item_value;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    srax_front #(
        .COLUMN_BITS (COLUMN_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .entry_column (entry_column),
        .entry_value  (entry_value),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_op      (item_op),
        .item_column  (item_column),
        .item_value   (item_value)
    );

    srax_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COLUMN_BITS (COLUMN_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_op     (item_op),
        .item_column (item_column),
        .item_value  (item_value),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_sel     (cfg_index),
        .cfg_wdata   (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .out_column  (out_column),
        .out_value   (out_value),
        .term_count  (term_count),
        .last        (last)
    );

endmodule

/* verif/tb_sparse_row_axpy_mod_p.sv */
`timescale 1ns / 100ps

module tb_sparse_row_axpy_mod_p;
    import srax_pkg::*;

    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int CB = COLUMN_BITS_DEF;
    localparam int VB = VALUE_BITS_DEF;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic [1:0]    kind;
        logic [CB-1:0] column;
        logic [VB-1:0] value;
        logic [15:0]   count;
        logic          last;
    } merge_beat_t;

    typedef struct packed {
        logic [CB-1:0] column;
        logic [VB-1:0] value;
    } term_t;

    // directed row: op, column, value, check typed expectation, expected beat
    typedef struct {
        op_t           op;
        logic [CB-1:0] column;
        logic [VB-1:0] value;
        bit            typed;
        merge_beat_t   beat;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] cmd;
    logic [CB-1:0] entry_column;
    logic [VB-1:0] entry_value;
    logic out_valid;
    logic out_ready;
    logic [1:0] kind;
    logic [CB-1:0] out_column;
    logic [VB-1:0] out_value;
    logic [15:0] term_count;
    logic last;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [VB-1:0] cfg_data;

    sparse_row_axpy_mod_p dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .entry_column(entry_column), .entry_value(entry_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .out_column(out_column), .out_value(out_value),
        .term_count(term_count), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // predictor state
    logic [VB-1:0] pr_modulus;
    logic [VB-1:0] pr_scale;
    term_t p_terms[$];
    term_t q_terms[$];
    bit p_done;
    bit q_done;
    int unsigned merged_count;

    merge_beat_t pending_beats[$];
    int errors;
    int beats_seen;
    int rows_closed;
    int overflows_seen;
    int items_sent;
    bit idle_free;

    function automatic logic [VB-1:0] mod_reduce(logic [63:0] x);
        logic [63:0] m;
        m = (pr_modulus == 0) ? (64'd1 << VB) : 64'(pr_modulus);
        return VB'(x % m);
    endfunction

    function automatic logic [VB-1:0] scaled(logic [VB-1:0] y);
        return mod_reduce(64'(pr_scale) * 64'(y));
    endfunction

    task automatic push_beat(logic [1:0] k, logic [CB-1:0] c, logic [VB-1:0] v,
                             logic [15:0] n);
        merge_beat_t b;
        b.kind = k;
        b.column = c;
        b.value = v;
        b.count = n;
        b.last = 1'b0;
        pending_beats.push_back(b);
    endtask

    task automatic push_term(logic [CB-1:0] c, logic [VB-1:0] v);
        push_beat(KIND_ENTRY, c, v, 16'd0);
        if (merged_count < 32'hFFFF)
            merged_count++;
    endtask

    // merge one input item into the expected beat queue
    task automatic predict_merge(op_t op, logic [CB-1:0] c, logic [VB-1:0] v);
        int start;
        term_t t;
        term_t a;
        term_t b;
        logic [VB-1:0] s;
        start = pending_beats.size();
        t.column = c;
        t.value = v;
        case (op)
            OP_PUSH_P:
                if (!p_done)
                begin
                    if (p_terms.size() >= QD)
                        push_beat(KIND_OVERFLOW, c, v, 16'd0);
                    else
                        p_terms.push_back(t);
                end
            OP_PUSH_Q:
                if (!q_done)
                begin
                    if (q_terms.size() >= QD)
                        push_beat(KIND_OVERFLOW, c, v, 16'd0);
                    else
                        q_terms.push_back(t);
                end
            OP_END_P: p_done = 1;
            default: q_done = 1;
        endcase
        forever
        begin
            if (p_terms.size() > 0 && q_terms.size() > 0)
            begin
                a = p_terms[0];
                b = q_terms[0];
                if (a.column > b.column)
                begin
                    push_term(a.column, a.value);
                    void'(p_terms.pop_front());
                end
                else if (a.column < b.column)
                begin
                    push_term(b.column, scaled(b.value));
                    void'(q_terms.pop_front());
                end
                else
                begin
                    s = mod_reduce(64'(a.value) + 64'(pr_scale) * 64'(b.value));
                    if (s != 0)
                        push_term(a.column, s);
                    void'(p_terms.pop_front());
                    void'(q_terms.pop_front());
                end
            end
            else if (p_terms.size() > 0 && q_done)
            begin
                push_term(p_terms[0].column, p_terms[0].value);
                void'(p_terms.pop_front());
            end
            else if (q_terms.size() > 0 && p_done)
            begin
                push_term(q_terms[0].column, scaled(q_terms[0].value));
                void'(q_terms.pop_front());
            end
            else
                break;
        end
        if (p_done && q_done && p_terms.size() == 0 && q_terms.size() == 0)
        begin
            push_beat(KIND_ROW_END, '0, '0, 16'(merged_count));
            p_done = 0;
            q_done = 0;
            merged_count = 0;
        end
        if (pending_beats.size() > start)
            pending_beats[pending_beats.size()-1].last = 1'b1;
    endtask

    // send one item, predicting it at acceptance
    task automatic send_item(op_t op, logic [CB-1:0] c, logic [VB-1:0] v);
        cfg_valid <= 1'b0;
        while (!idle_free && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        entry_column <= c;
        entry_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        predict_merge(op, c, v);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [VB-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_MODULUS)
            pr_modulus = d;
        else
            pr_scale = d;
    endtask

    // receive side with random stalls
    always @(posedge clk)
    begin
        merge_beat_t exp_b;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                beats_seen++;
                if (pending_beats.size() == 0)
                begin
                    $error("unexpected beat kind=%0d column=%0d", kind, out_column);
                    errors++;
                end
                else
                begin
                    exp_b = pending_beats.pop_front();
                    if (kind != exp_b.kind)
                    begin
                        $error("kind: expected %0d actual %0d", exp_b.kind, kind);
                        errors++;
                    end
                    if (out_column != exp_b.column)
                    begin
                        $error("out_column: expected %0d actual %0d", exp_b.column, out_column);
                        errors++;
                    end
                    if (out_value != exp_b.value)
                    begin
                        $error("out_value: expected %0d actual %0d", exp_b.value, out_value);
                        errors++;
                    end
                    if (term_count != exp_b.count)
                    begin
                        $error("term_count: expected %0d actual %0d", exp_b.count, term_count);
                        errors++;
                    end
                    if (last != exp_b.last)
                    begin
                        $error("last: expected %0d actual %0d", exp_b.last, last);
                        errors++;
                    end
                    if (exp_b.kind == KIND_ROW_END)
                        rows_closed++;
                    if (exp_b.kind == KIND_OVERFLOW)
                        overflows_seen++;
                end
            end
            out_ready <= idle_free || ($urandom_range(99) >= 7);
        end
    end

    // random row pair with mostly descending columns and a little noise
    task automatic send_row_pair(int max_len, bit tiny_cols);
        int np;
        int nq;
        int cp;
        int cq;
        int r;
        logic [VB-1:0] v;
        np = $urandom_range(max_len);
        nq = $urandom_range(max_len);
        cp = tiny_cols ? 40 : 65535;
        cq = cp;
        while (np > 0 || nq > 0)
        begin
            r = $urandom_range(99);
            v = (pr_modulus > 1) ? VB'($urandom_range(pr_modulus - 1))
                                 : VB'($urandom);
            if (r < 3)
                v = VB'($urandom);
            if (np > 0 && (nq == 0 || $urandom_range(1)))
            begin
                cp = cp - $urandom_range(tiny_cols ? 2 : 3000);
                if (cp < 0) cp = 0;
                if (r >= 96) cp = $urandom_range(65535);
                send_item(OP_PUSH_P, CB'(cp), v);
                np--;
            end
            else
            begin
                cq = cq - $urandom_range(tiny_cols ? 2 : 3000);
                if (cq < 0) cq = 0;
                if (r >= 96) cq = $urandom_range(65535);
                send_item(OP_PUSH_Q, CB'(cq), v);
                nq--;
            end
        end
        if ($urandom_range(1))
        begin
            send_item(OP_END_P, CB'($urandom), VB'($urandom));
            if ($urandom_range(9) == 0)
                send_item(OP_END_P, '0, '0);
            send_item(OP_END_Q, CB'($urandom), VB'($urandom));
        end
        else
        begin
            send_item(OP_END_Q, CB'($urandom), VB'($urandom));
            if ($urandom_range(9) == 0)
                send_item(OP_PUSH_Q, CB'($urandom), VB'($urandom));
            send_item(OP_END_P, CB'($urandom), VB'($urandom));
        end
    endtask

    function automatic stim_row_t mk(op_t op, int c, int v, bit typed, merge_beat_t b);
        stim_row_t s;
        s.op = op;
        s.column = CB'(c);
        s.value = VB'(v);
        s.typed = typed;
        s.beat = b;
        return s;
    endfunction

    stim_row_t directed[$];
    merge_beat_t none_b;
    merge_beat_t got_b;

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = OP_PUSH_P;
        entry_column = '0;
        entry_value = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODULUS;
        cfg_data = '0;
        errors = 0;
        beats_seen = 0;
        rows_closed = 0;
        overflows_seen = 0;
        items_sent = 0;
        idle_free = 0;
        pr_modulus = VB'(MODULUS_RESET);
        pr_scale = VB'(SCALE_RESET);
        p_done = 0;
        q_done = 0;
        merged_count = 0;
        none_b = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under reset settings
        directed.push_back(mk(OP_END_P, 65535, 32'h7FFFFFFF, 0, none_b));
        got_b = '{KIND_ROW_END, 16'd0, 31'd0, 16'd0, 1'b1};
        directed.push_back(mk(OP_END_Q, 0, 0, 1, got_b));
        directed.push_back(mk(OP_PUSH_P, 65535, 32002, 0, none_b));
        directed.push_back(mk(OP_PUSH_Q, 65535, 1, 0, none_b));
        directed.push_back(mk(OP_PUSH_P, 100, 5, 0, none_b));
        directed.push_back(mk(OP_PUSH_Q, 100, 7, 0, none_b));
        directed.push_back(mk(OP_PUSH_Q, 0, 32002, 0, none_b));
        directed.push_back(mk(OP_PUSH_P, 50, 0, 0, none_b));
        directed.push_back(mk(OP_END_P, 0, 0, 0, none_b));
        directed.push_back(mk(OP_PUSH_P, 9, 9, 0, none_b));
        directed.push_back(mk(OP_END_P, 0, 0, 0, none_b));
        directed.push_back(mk(OP_END_Q, 0, 0, 0, none_b));
        foreach (directed[i])
        begin
            send_item(directed[i].op, directed[i].column, directed[i].value);
            // typed rows: the last predicted beat must match the table
            if (directed[i].typed)
            begin
                got_b = (pending_beats.size() > 0) ?
                        pending_beats[pending_beats.size()-1] : none_b;
                if (got_b != directed[i].beat)
                begin
                    $error("directed beat: expected %h actual %h", directed[i].beat, got_b);
                    errors++;
                end
            end
        end
        wait_drained();

        // overflow: fill P past its depth with Q open
        for (int i = 0; i < QD + 2; i++)
            send_item(OP_PUSH_P, CB'(60000 - i), VB'(i + 1));
        send_item(OP_PUSH_Q, 16'hFFFF, 31'h7FFFFFFE);
        send_item(OP_END_Q, '0, '0);
        send_item(OP_END_P, '0, '0);
        wait_drained();

        // modulus one and zero, values not below modulus
        write_reg(REG_MODULUS, 31'd1);
        write_reg(REG_SCALE, 31'h7FFFFFFE);
        send_item(OP_PUSH_P, CB'(10), 31'h7FFFFFFF);
        send_item(OP_PUSH_Q, CB'(10), 31'h7FFFFFFF);
        send_item(OP_PUSH_Q, CB'(5), VB'(3));
        send_item(OP_END_P, '0, '0);
        send_item(OP_END_Q, '0, '0);
        wait_drained();
        write_reg(REG_MODULUS, 31'd0);
        send_item(OP_PUSH_Q, CB'(7), 31'h7FFFFFFF);
        send_item(OP_PUSH_P, CB'(7), 31'h7FFFFFFF);
        send_item(OP_END_Q, '0, '0);
        send_item(OP_END_P, '0, '0);
        wait_drained();

        // random phases across several settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_MODULUS, 31'd7); write_reg(REG_SCALE, 31'd3); end
                1: begin write_reg(REG_MODULUS, 31'h7FFFFFFF);
                         write_reg(REG_SCALE, 31'h7FFFFFFE); end
                2: begin write_reg(REG_MODULUS, 31'd2); write_reg(REG_SCALE, 31'd0); end
                3: begin write_reg(REG_MODULUS, 31'd65521);
                         write_reg(REG_SCALE, VB'($urandom_range(65520))); end
                default: begin write_reg(REG_MODULUS, VB'(MODULUS_RESET));
                               write_reg(REG_SCALE, VB'(SCALE_RESET)); end
            endcase
            idle_free = (ph == 2);
            while (items_sent < 50 + 55 * (ph + 1))
                send_row_pair(ph == 1 ? 12 : 8, ph == 0 || ph == 3);
            // hold off until all beats are back
            wait_drained();
        end

        $display("covered %0d items, %0d beats, %0d rows, %0d overflows",
                 items_sent, beats_seen, rows_closed, overflows_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
